FILE: hw/rtl/drr_pkg.sv
package drr_pkg;

    localparam int N_FLOWS         = 16;
    localparam int STORE_DEPTH_DEF = 64;

    localparam logic [15:0] QUANTUM_RST = 16'd250;
    localparam logic [6:0]  LIMIT_RST   = 7'd50;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        OC_NONE = 2'd0,
        OC_DEQ  = 2'd1,
        OC_ENQ  = 2'd2,
        OC_DROP = 2'd3
    } t_outcome;

    typedef enum logic {
        CFG_QUANTUM = 1'b0,
        CFG_LIMIT   = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ENQ_WR,
        ST_PRI_POP,
        ST_VIS_RD,
        ST_VIS_CMP
    } t_state;

    // Classified request word handed from front to engine.
    typedef struct packed {
        t_op         op;
        logic        high;
        logic [3:0]  flow;
        logic [15:0] size;
        logic [15:0] tag;
    } t_req;

    typedef struct packed {
        t_outcome    outcome;
        logic [3:0]  flow;
        logic        high;
        logic [15:0] size;
        logic [15:0] tag;
        logic [4:0]  active;
    } t_res;

endpackage

FILE: hw/rtl/drr_front.sv
module drr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  logic          i_req_type,
    input  logic [3:0]    i_flow_id,
    input  logic          i_high_priority,
    input  logic [15:0]   i_pkt_size,
    input  logic [15:0]   i_pkt_tag,
    output logic          o_req_valid,
    output drr_pkg::t_req o_req,
    input  logic          i_req_take
);
    import drr_pkg::*;

    t_req       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_req       req_in;
    logic       wr;
    logic       rd;

    // Classify: fold the flow into range and tag the operation.
    always_comb begin
        req_in.op   = i_req_type ? OP_DEQ : OP_ENQ;
        req_in.high = i_high_priority;
        req_in.flow = 4'(i_flow_id % N_FLOWS);
        req_in.size = i_pkt_size;
        req_in.tag  = i_pkt_tag;
    end

    assign full        = (r_cnt == 2'd2);
    assign wr          = push && !full;
    assign o_req_valid = (r_cnt != 2'd0);
    assign rd          = o_req_valid && i_req_take;
    assign o_req       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_q[r_wp] <= req_in;
                r_wp      <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

endmodule

FILE: hw/rtl/drr_engine.sv
module drr_engine #(
    parameter int STORE_DEPTH = drr_pkg::STORE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [15:0]   i_quantum,
    input  logic [6:0]    i_limit,
    input  logic          i_req_valid,
    input  drr_pkg::t_req i_req,
    output logic          o_req_take,
    output logic          empty,
    input  logic          pop,
    output drr_pkg::t_res o_res
);
    import drr_pkg::*;

    localparam int FW = $clog2(N_FLOWS);
    localparam int QW = $clog2(N_FLOWS + 1);
    localparam int SW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int AW = $clog2(N_FLOWS + 2);
    localparam int LW = ((CW > 7) ? CW : 7) + 1;
    localparam logic [QW-1:0] PRIO_Q = QW'(N_FLOWS);

    t_state        r_state;
    t_state        n_state;
    t_req          r_req;
    logic [SW-1:0] r_head   [N_FLOWS + 1];
    logic [SW-1:0] r_tail   [N_FLOWS + 1];
    logic [CW-1:0] r_cnt    [N_FLOWS + 1];
    logic [31:0]   r_def    [N_FLOWS];
    logic [FW-1:0] r_rnext  [N_FLOWS];
    logic [FW-1:0] r_rprev  [N_FLOWS];
    logic [FW-1:0] r_cur;
    logic          r_cur_valid;
    logic          r_turn;
    logic [CW-1:0] r_total;
    logic [AW-1:0] r_active;
    logic [CW-1:0] r_sp;
    logic [CW-1:0] r_fresh;
    logic [FW-1:0] r_f;
    logic          r_first;
    logic          r_out_valid;
    t_res          r_out;

    logic [31:0]   m_pkt   [STORE_DEPTH];
    logic [SW-1:0] m_link  [STORE_DEPTH];
    logic [SW-1:0] m_stack [STORE_DEPTH];
    logic [31:0]   r_pkt_rd;
    logic [SW-1:0] r_link_rd;
    logic [SW-1:0] r_stack_rd;

    logic [FW+3:0] req_flow_ext;
    logic [FW-1:0] req_f;
    logic [QW-1:0] req_q;
    logic          q_empty;
    logic          drop;
    logic [SW-1:0] slot_alloc;
    logic [CW-1:0] sp_m1;
    logic [QW-1:0] sel_q;
    logic [SW-1:0] sel_head;
    logic          sel_last;
    logic [32:0]   acc;
    logic [15:0]   head_size;
    logic          fits;
    logic [15:0]   qeff;
    logic [FW+3:0] f_ext;
    logic [AW+4:0] act_ext_same;
    logic [AW+4:0] act_ext_inc;
    logic [AW+4:0] act_ext_dec;
    logic          pkt_we;
    logic          link_we;
    logic          stk_we;
    logic [FW-1:0] nx;
    logic [FW-1:0] pv;

    assign req_flow_ext = (FW + 4)'(r_req.flow);
    assign req_f        = req_flow_ext[FW-1:0];
    assign req_q        = r_req.high ? PRIO_Q : QW'(req_f);
    assign q_empty      = (r_cnt[req_q] == '0);
    assign drop         = (LW'(r_total) + LW'(1) >= LW'(i_limit))
                       || (r_total >= CW'(STORE_DEPTH));
    assign sp_m1        = r_sp - CW'(1);
    assign slot_alloc   = (r_sp != '0) ? r_stack_rd : r_fresh[SW-1:0];
    assign qeff         = (i_quantum == 16'd0) ? 16'd1 : i_quantum;
    assign head_size    = r_pkt_rd[31:16];
    assign acc          = {1'b0, r_def[r_f]} + ((r_first && r_turn) ? 33'd0 : 33'(qeff));
    assign fits         = (acc >= 33'(head_size));
    assign f_ext        = (FW + 4)'(r_f);
    assign act_ext_same = (AW + 5)'(r_active);
    assign act_ext_inc  = (AW + 5)'(r_active + AW'(1));
    assign act_ext_dec  = (AW + 5)'(r_active - AW'(1));
    assign nx           = r_rnext[r_f];
    assign pv           = r_rprev[r_f];

    // Queue whose head is read this cycle.
    always_comb begin
        case (r_state)
            ST_DISPATCH: sel_q = (r_cnt[PRIO_Q] != '0) ? PRIO_Q : QW'(r_cur);
            ST_PRI_POP:  sel_q = PRIO_Q;
            default:     sel_q = QW'(r_f);
        endcase
    end
    assign sel_head = r_head[sel_q];
    assign sel_last = (r_cnt[sel_q] == CW'(1));

    always_comb begin
        n_state    = r_state;
        o_req_take = 1'b0;
        pkt_we     = 1'b0;
        link_we    = 1'b0;
        stk_we     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid && !r_out_valid) begin
                    o_req_take = 1'b1;
                    n_state    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (r_req.op == OP_ENQ) begin
                    n_state = drop ? ST_IDLE : ST_ENQ_WR;
                end else if (r_cnt[PRIO_Q] != '0) begin
                    n_state = ST_PRI_POP;
                end else if (r_cur_valid) begin
                    n_state = ST_VIS_CMP;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_ENQ_WR: begin
                pkt_we  = 1'b1;
                link_we = !q_empty;
                n_state = ST_IDLE;
            end
            ST_PRI_POP: begin
                stk_we  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_VIS_RD: begin
                n_state = ST_VIS_CMP;
            end
            ST_VIS_CMP: begin
                stk_we  = fits;
                n_state = fits ? ST_IDLE : ST_VIS_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pkt_rd   <= m_pkt[sel_head];
        r_link_rd  <= m_link[sel_head];
        r_stack_rd <= m_stack[sp_m1[SW-1:0]];
        if (pkt_we) begin
            m_pkt[slot_alloc] <= {r_req.size, r_req.tag};
        end
        if (link_we) begin
            m_link[r_tail[req_q]] <= slot_alloc;
        end
        if (stk_we) begin
            m_stack[r_sp[SW-1:0]] <= sel_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur_valid <= 1'b0;
            r_turn      <= 1'b0;
            r_total     <= '0;
            r_active    <= '0;
            r_sp        <= '0;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
            r_cur       <= '0;
            for (int i = 0; i < N_FLOWS + 1; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_req_take) begin
                        r_req <= i_req;
                    end
                end
                ST_DISPATCH: begin
                    r_f     <= r_cur;
                    r_first <= 1'b1;
                    if (r_req.op == OP_ENQ) begin
                        if (drop) begin
                            r_out_valid <= 1'b1;
                            r_out       <= '{OC_DROP, r_req.flow, r_req.high, r_req.size,
                                             r_req.tag, act_ext_same[4:0]};
                        end
                    end else if (r_cnt[PRIO_Q] == '0 && !r_cur_valid) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{OC_NONE, 4'd0, 1'b0, 16'd0, 16'd0,
                                         act_ext_same[4:0]};
                    end
                end
                ST_ENQ_WR: begin
                    // Take a recycled slot first, else the next never-used one.
                    if (r_sp != '0) begin
                        r_sp <= sp_m1;
                    end else begin
                        r_fresh <= r_fresh + CW'(1);
                    end
                    if (q_empty) begin
                        r_head[req_q] <= slot_alloc;
                        r_active      <= r_active + AW'(1);
                        if (!r_req.high) begin
                            r_def[req_f] <= 32'd0;
                            if (!r_cur_valid) begin
                                r_rnext[req_f] <= req_f;
                                r_rprev[req_f] <= req_f;
                                r_cur          <= req_f;
                                r_cur_valid    <= 1'b1;
                                r_turn         <= 1'b0;
                            end else begin
                                // Join just behind the current flow.
                                r_rnext[r_rprev[r_cur]] <= req_f;
                                r_rprev[req_f]          <= r_rprev[r_cur];
                                r_rnext[req_f]          <= r_cur;
                                r_rprev[r_cur]          <= req_f;
                            end
                        end
                    end
                    r_tail[req_q] <= slot_alloc;
                    r_cnt[req_q]  <= r_cnt[req_q] + CW'(1);
                    r_total       <= r_total + CW'(1);
                    r_out_valid   <= 1'b1;
                    r_out         <= '{OC_ENQ, r_req.flow, r_req.high, r_req.size, r_req.tag,
                                       q_empty ? act_ext_inc[4:0] : act_ext_same[4:0]};
                end
                ST_PRI_POP: begin
                    r_head[PRIO_Q] <= r_link_rd;
                    r_cnt[PRIO_Q]  <= r_cnt[PRIO_Q] - CW'(1);
                    r_total        <= r_total - CW'(1);
                    r_sp           <= r_sp + CW'(1);
                    if (sel_last) begin
                        r_active <= r_active - AW'(1);
                    end
                    r_out_valid <= 1'b1;
                    r_out       <= '{OC_DEQ, 4'd0, 1'b1, r_pkt_rd[31:16], r_pkt_rd[15:0],
                                     sel_last ? act_ext_dec[4:0] : act_ext_same[4:0]};
                end
                ST_VIS_CMP: begin
                    if (fits) begin
                        r_def[r_f]  <= acc[31:0] - 32'(head_size);
                        r_head[sel_q] <= r_link_rd;
                        r_cnt[sel_q]  <= r_cnt[sel_q] - CW'(1);
                        r_total     <= r_total - CW'(1);
                        r_sp        <= r_sp + CW'(1);
                        if (sel_last) begin
                            r_active <= r_active - AW'(1);
                            r_turn   <= 1'b0;
                            if (nx == r_f) begin
                                r_cur_valid <= 1'b0;
                                r_cur       <= r_f;
                            end else begin
                                r_rnext[pv] <= nx;
                                r_rprev[nx] <= pv;
                                r_cur       <= nx;
                            end
                        end else begin
                            r_cur  <= r_f;
                            r_turn <= 1'b1;
                        end
                        r_out_valid <= 1'b1;
                        r_out       <= '{OC_DEQ, f_ext[3:0], 1'b0, head_size, r_pkt_rd[15:0],
                                         sel_last ? act_ext_dec[4:0] : act_ext_same[4:0]};
                    end else begin
                        r_def[r_f] <= acc[31:0];
                        r_f        <= nx;
                        r_first    <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign empty = !r_out_valid;
    assign o_res = r_out;

    a_no_busy_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && r_state != ST_DISPATCH) |-> !r_out_valid)
        else $error("engine busy while a result waits");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(STORE_DEPTH))
        else $error("occupancy above store depth");

    a_active_vs_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total == '0) == (r_active == '0))
        else $error("active count disagrees with occupancy");

    a_ring_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (r_active != '0))
        else $error("ring holds a flow while all queues are empty");

endmodule

FILE: hw/rtl/drr_scheduler_with_priority_queue.sv
// Packet scheduler: one strict-priority queue in front of per-flow queues
// served by deficit round robin. Push a word with req_type 0 to enqueue a
// packet (tail drop when occupancy plus one reaches queue_limit, or when the
// packet store is full) and with req_type 1 to ask for one packet; every
// word yields exactly one result word. A small input queue takes words while
// the engine works and while a result waits to be popped. A DRR dequeue
// visits flows in ring order until one's deficit covers its head packet;
// each visit is one read of the packet store followed by one compare. The
// engine starts the next word only once the previous result has been
// popped. No clearing pass is needed after reset: never-used store slots
// are handed out by a counter.
module drr_scheduler_with_priority_queue #(
    parameter int STORE_DEPTH = drr_pkg::STORE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic        i_req_type,
    input  logic [3:0]  i_flow_id,
    input  logic        i_high_priority,
    input  logic [15:0] i_pkt_size,
    input  logic [15:0] i_pkt_tag,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_outcome,
    output logic [3:0]  o_out_flow,
    output logic        o_out_high,
    output logic [15:0] o_out_size,
    output logic [15:0] o_out_tag,
    output logic [4:0]  o_active_flows
);
    import drr_pkg::*;

    logic [15:0] r_quantum;
    logic [6:0]  r_limit;
    logic        req_valid;
    t_req        req;
    logic        req_take;
    t_res        res;

    // Configuration registers: write only while idle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QUANTUM_RST;
            r_limit   <= LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_QUANTUM: r_quantum <= i_cfg_wdata;
                CFG_LIMIT:   r_limit   <= i_cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    // Front: accept and classify words.
    drr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_req_type     (i_req_type),
        .i_flow_id      (i_flow_id),
        .i_high_priority(i_high_priority),
        .i_pkt_size     (i_pkt_size),
        .i_pkt_tag      (i_pkt_tag),
        .o_req_valid    (req_valid),
        .o_req          (req),
        .i_req_take     (req_take)
    );

    // Engine: queues, DRR ring and the result register.
    drr_engine #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_quantum  (r_quantum),
        .i_limit    (r_limit),
        .i_req_valid(req_valid),
        .i_req      (req),
        .o_req_take (req_take),
        .empty      (empty),
        .pop        (pop),
        .o_res      (res)
    );

    assign o_outcome      = res.outcome;
    assign o_out_flow     = res.flow;
    assign o_out_high     = res.high;
    assign o_out_size     = res.size;
    assign o_out_tag      = res.tag;
    assign o_active_flows = res.active;

endmodule

FILE: bench/drr_scheduler_with_priority_queue_tb.sv
`timescale 1ns / 1ps

module drr_scheduler_with_priority_queue_tb;
    import drr_pkg::*;

    localparam int NF        = 16;
    localparam int NQ        = NF + 1;
    localparam int PRIO      = NF;
    localparam int SLOTS     = 64;
    localparam int MAX_CYC   = 20_000_000;
    localparam int PHASE_LEN = 320;

    typedef struct packed {
        logic [15:0] size;
        logic [15:0] tag;
    } t_pkt;

    // Scoreboard: tracks the scheduler's queues, ring and deficits and holds
    // the result words still owed by the block.
    class sched_scoreboard;
        logic [15:0] quantum;
        logic [6:0]  limit;
        t_pkt        fifo[NQ][$];
        logic [31:0] deficit[NF];
        bit          turn[NF];
        int          rnext[NF];
        int          rprev[NF];
        bit          cur_valid;
        int          cur;
        int          total;
        int          active;
        t_res        owed[$];
        int          errors;
        int          n_deq;
        int          n_drop;
        int          n_none;

        function new();
            quantum = QUANTUM_RST;
            limit = LIMIT_RST;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [15:0] v);
            if (idx == CFG_QUANTUM) quantum = v;
            else limit = v[6:0];
        endfunction

        function void ring_join(int f);
            int p;
            if (!cur_valid) begin
                rnext[f] = f;
                rprev[f] = f;
                cur = f;
                cur_valid = 1;
            end else begin
                p = rprev[cur];
                rnext[p] = f;
                rprev[f] = p;
                rnext[f] = cur;
                rprev[cur] = f;
            end
        endfunction

        function void ring_leave(int f);
            if (rnext[f] == f) begin
                cur_valid = 0;
            end else begin
                rnext[rprev[f]] = rnext[f];
                rprev[rnext[f]] = rprev[f];
                if (cur == f) cur = rnext[f];
            end
        endfunction

        function t_pkt take_head(int q);
            t_pkt k;
            k = fifo[q].pop_front();
            total--;
            if (fifo[q].size() == 0) active--;
            return k;
        endfunction

        // Work out the result word for one accepted request.
        function void note(t_req r);
            t_res              e;
            t_pkt              k;
            int                q, n, pw, w, f;
            int                order[NF];
            longint unsigned   qq, rw, s, a, rr, visits, added;
            e = '0;
            if (r.op == OP_ENQ) begin
                q = r.high ? PRIO : int'(r.flow);
                e.flow = r.flow;
                e.high = r.high;
                e.size = r.size;
                e.tag = r.tag;
                if (total + 1 >= int'(limit) || total >= SLOTS) begin
                    e.outcome = OC_DROP;
                    n_drop++;
                end else begin
                    fifo[q].push_back({r.size, r.tag});
                    total++;
                    if (fifo[q].size() == 1) begin
                        active++;
                        if (!r.high) begin
                            deficit[r.flow] = 0;
                            turn[r.flow] = 0;
                            ring_join(r.flow);
                        end
                    end
                    e.outcome = OC_ENQ;
                end
            end else if (fifo[PRIO].size() != 0) begin
                k = take_head(PRIO);
                e.outcome = OC_DEQ;
                e.high = 1;
                e.size = k.size;
                e.tag = k.tag;
                n_deq++;
            end else if (cur_valid) begin
                qq = (quantum != 0) ? quantum : 1;
                n = 0;
                f = cur;
                do begin
                    order[n] = f;
                    n++;
                    f = rnext[f];
                end while (f != cur && n < NF);
                // find the flow whose deficit covers its head packet first
                pw = 0;
                rw = 0;
                for (int p = 0; p < n; p++) begin
                    s = fifo[order[p]][0].size;
                    a = deficit[order[p]] + ((p == 0 && turn[order[p]]) ? 0 : qq);
                    rr = (a >= s) ? 0 : (s - a + qq - 1) / qq;
                    if (p == 0 || rr < rw) begin
                        rw = rr;
                        pw = p;
                    end
                end
                // credit every flow for the turns it got meanwhile
                for (int p = 0; p < n; p++) begin
                    visits = (p <= pw) ? rw + 1 : rw;
                    added = visits * qq;
                    if (p == 0 && turn[order[p]]) added -= qq;
                    deficit[order[p]] = deficit[order[p]] + added[31:0];
                    turn[order[p]] = 0;
                end
                w = order[pw];
                k = take_head(w);
                deficit[w] = deficit[w] - k.size;
                turn[w] = 1;
                cur = w;
                if (fifo[w].size() == 0) begin
                    turn[w] = 0;
                    ring_leave(w);
                end
                e.outcome = OC_DEQ;
                e.flow = 4'(w);
                e.size = k.size;
                e.tag = k.tag;
                n_deq++;
            end else begin
                e.outcome = OC_NONE;
                n_none++;
            end
            e.active = 5'(active);
            owed.push_back(e);
        endfunction

        function void cmp(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check(t_res r);
            t_res e;
            if (owed.size() == 0) begin
                $error("result word with nothing owed: outcome %0d tag %0d",
                       r.outcome, r.tag);
                errors++;
                return;
            end
            e = owed.pop_front();
            cmp("outcome", e.outcome, r.outcome);
            cmp("out_flow", e.flow, r.flow);
            cmp("out_high", e.high, r.high);
            cmp("out_size", e.size, r.size);
            cmp("out_tag", e.tag, r.tag);
            cmp("active_flows", e.active, r.active);
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic        i_cfg_idx = 0;
    logic [15:0] i_cfg_wdata = 0;
    logic        push = 0;
    logic        full;
    logic        i_req_type = 0;
    logic [3:0]  i_flow_id = 0;
    logic        i_high_priority = 0;
    logic [15:0] i_pkt_size = 0;
    logic [15:0] i_pkt_tag = 0;
    logic        empty;
    logic        pop = 0;
    logic [1:0]  o_outcome;
    logic [3:0]  o_out_flow;
    logic        o_out_high;
    logic [15:0] o_out_size;
    logic [15:0] o_out_tag;
    logic [4:0]  o_active_flows;

    sched_scoreboard sb = new();
    int tx_idle = 0;   // percent of cycles the sender holds off
    int rx_idle = 0;   // percent of cycles the receiver stalls
    int cycles = 0;
    int sent = 0;

    drr_scheduler_with_priority_queue dut (.*);

    always #5 i_clk = ~i_clk;

    // Stall the result side at random; change only on the falling edge.
    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= rx_idle);
    end

    // Sample both handshakes at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full)
                sb.note('{op: t_op'(i_req_type), high: i_high_priority, flow: i_flow_id,
                          size: i_pkt_size, tag: i_pkt_tag});
            if (pop && !empty)
                sb.check('{outcome: t_outcome'(o_outcome), flow: o_out_flow,
                           high: o_out_high, size: o_out_size, tag: o_out_tag,
                           active: o_active_flows});
        end
    end

    // Bound the run; a hang ends here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("timeout after %0d cycles", cycles);
            $display("drr_scheduler_with_priority_queue verification failed");
            $finish;
        end
    end

    // Push one word; hold it until the block takes it.
    task automatic send_word(t_op op, logic [3:0] f, logic h, logic [15:0] s,
                             logic [15:0] t);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle) begin
            push = 0;
            @(negedge i_clk);
        end
        push = 1;
        i_req_type = op;
        i_flow_id = f;
        i_high_priority = h;
        i_pkt_size = s;
        i_pkt_tag = t;
        do @(posedge i_clk); while (full);
        sent++;
    endtask

    // Drop push and wait for every owed word, then let the engine settle.
    task automatic drain();
        @(negedge i_clk);
        push = 0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] v);
        drain();
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 0;
        sb.set_reg(idx, v);
    endtask

    // Random traffic; sizes stay within twelve quanta so DRR visits stay bounded.
    task automatic random_words(int count, int enq_pct);
        int          max_size;
        logic [3:0]  f;
        max_size = (sb.quantum == 0) ? 12 : sb.quantum * 12;
        if (max_size > 65535) max_size = 65535;
        repeat (count) begin
            f = ($urandom_range(1) != 0) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
            if ($urandom_range(99) < enq_pct)
                send_word(OP_ENQ, f, $urandom_range(99) < 20,
                          16'($urandom_range(max_size)), 16'($urandom));
            else
                send_word(OP_DEQ, 4'($urandom), 1'($urandom), 16'($urandom),
                          16'($urandom));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: field extremes, priority and DRR dequeue, empty dequeue.
        send_word(OP_ENQ, 4'd0, 1'b0, 16'd0, 16'd0);
        send_word(OP_ENQ, 4'd15, 1'b0, 16'hFFFF, 16'hFFFF);
        send_word(OP_ENQ, 4'd9, 1'b1, 16'd1234, 16'hA5A5);
        send_word(OP_DEQ, 4'd0, 1'b0, 16'd0, 16'd0);
        send_word(OP_DEQ, 4'd0, 1'b0, 16'd0, 16'd0);
        send_word(OP_DEQ, 4'd0, 1'b0, 16'd0, 16'd0);
        send_word(OP_DEQ, 4'd15, 1'b1, 16'hFFFF, 16'hFFFF);
        send_word(OP_ENQ, 4'd3, 1'b0, 16'd300, 16'd1);
        send_word(OP_ENQ, 4'd7, 1'b0, 16'd100, 16'd2);
        send_word(OP_ENQ, 4'd3, 1'b0, 16'd50, 16'd3);
        send_word(OP_ENQ, 4'd11, 1'b0, 16'd250, 16'd4);
        repeat (5) send_word(OP_DEQ, 4'd0, 1'b0, 16'd0, 16'd0);
        // limit zero and one: every enqueue is dropped
        write_reg(CFG_LIMIT, 16'd0);
        send_word(OP_ENQ, 4'd5, 1'b0, 16'd10, 16'd5);
        write_reg(CFG_LIMIT, 16'd1);
        send_word(OP_ENQ, 4'd5, 1'b1, 16'd10, 16'd6);
        send_word(OP_DEQ, 4'd0, 1'b0, 16'd0, 16'd0);

        // Random phases: configuration changes only while idle.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin tx_idle = 21; rx_idle = 76; end
                1: begin tx_idle = 76; rx_idle = 21; end
                default: begin tx_idle = 0; rx_idle = 0; end
            endcase
            case (ph)
                0: begin
                    write_reg(CFG_QUANTUM, 16'd250);
                    write_reg(CFG_LIMIT, 16'd50);
                end
                1: begin
                    write_reg(CFG_QUANTUM, 16'd0);    // acts as one byte
                    write_reg(CFG_LIMIT, 16'd64);
                end
                2: begin
                    write_reg(CFG_QUANTUM, 16'hFFFF);
                    write_reg(CFG_LIMIT, 16'd2);
                end
                3: begin
                    write_reg(CFG_QUANTUM, 16'($urandom_range(600, 1)));
                    write_reg(CFG_LIMIT, 16'd64);
                end
                4: begin
                    write_reg(CFG_QUANTUM, 16'hFFFF);
                    write_reg(CFG_LIMIT, 16'($urandom_range(64, 3)));
                end
                default: begin
                    write_reg(CFG_QUANTUM, 16'($urandom_range(2000, 50)));
                    write_reg(CFG_LIMIT, 16'($urandom_range(64, 3)));
                end
            endcase
            random_words(PHASE_LEN / 2, 70);   // fill queues
            random_words(PHASE_LEN / 2, 45);   // drain toward empty
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("covered %0d words: %0d dequeued, %0d dropped, %0d empty dequeues",
                 sent, sb.n_deq, sb.n_drop, sb.n_none);
        $display("six register settings across three idle regimes, %0d cycles", cycles);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("drr_scheduler_with_priority_queue verification clean");
        end else begin
            if (sb.owed.size() != 0) $error("%0d result words never came", sb.owed.size());
            $display("drr_scheduler_with_priority_queue verification failed");
        end
        $finish;
    end

endmodule
